@@ hw/rtl/rpn_stack_calculator_defines.svh @@
// Assertion macros used by the checker file of the RPN stack calculator.
// Depends on nothing; the including scope must provide clk_i and rst_ni.
`ifndef RPN_STACK_CALCULATOR_DEFINES_SVH
`define RPN_STACK_CALCULATOR_DEFINES_SVH

// Clocked assertion that is switched off while reset is applied.
`define RPN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that is also checked while reset is applied.
`define RPN_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hw/rtl/rpn_pkg.sv @@
// Package of the RPN stack calculator: sizes, operation and status codes,
// transaction structs and the sequencer state type. Depends on nothing.
package rpn_pkg;

  // Stack size and field widths.
  localparam int unsigned DEPTH       = 64;
  localparam int unsigned DataW       = 32;
  localparam int unsigned FracW       = 16;
  localparam int unsigned OpW         = 3;
  localparam int unsigned StatusW     = 3;
  localparam int unsigned DepthFieldW = 7;
  localparam int unsigned CntW        = $clog2(DEPTH + 1);
  localparam int unsigned AddrW       = $clog2(DEPTH);
  localparam int unsigned DivCntW     = $clog2(DataW);

  // Clamp limits of a Q16.16 result.
  localparam logic [DataW-1:0] ValMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] ValMin = {1'b1, {(DataW-1){1'b0}}};

  typedef enum logic [OpW-1:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } rpn_op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_SATURATED = 3'd4
  } rpn_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_MUL,
    S_DIV
  } rpn_state_e;

  // Input transaction.
  typedef struct packed {
    logic [OpW-1:0]          operation;
    logic signed [DataW-1:0] operand_value;
  } rpn_req_t;

  // Result transaction.
  typedef struct packed {
    logic [StatusW-1:0]      status;
    logic signed [DataW-1:0] top_value;
    logic [DepthFieldW-1:0]  stack_depth;
  } rpn_rsp_t;

  // Status returned by the divider.
  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [DataW-1:0] quotient;
  } rpn_div_rsp_t;

endpackage

@@ hw/rtl/rpn_div.sv @@
// Radix-2 restoring divider for unsigned Q16.16 magnitudes, one quotient bit
// per cycle. Depends on rpn_pkg.
module rpn_div import rpn_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [DataW+FracW-1:0] dividend_i,
  input  logic [DataW-1:0]       divisor_i,
  output rpn_div_rsp_t           rsp_o
);

  logic [DataW-1:0]   rem_q, rem_d;
  logic [DataW-1:0]   quo_q, quo_d;
  logic [DataW-1:0]   dvs_q;
  logic               ovf_q;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DataW:0]     trial;
  logic [DataW:0]     shifted;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    shifted = {rem_q, quo_q[DataW-1]};
    trial   = shifted - {1'b0, dvs_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (busy_q) begin
      rem_d = trial[DataW] ? shifted[DataW-1:0] : trial[DataW-1:0];
      quo_d = {quo_q[DataW-2:0], ~trial[DataW]};
      cnt_d = cnt_q + DivCntW'(1);
      if (cnt_q == DivCntW'(DataW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers. A quotient of 2^32 or more is flagged up front, since
  // the high dividend bits then already reach the divisor.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {{(DataW-FracW){1'b0}}, dividend_i[DataW+FracW-1:DataW]};
      quo_q <= dividend_i[DataW-1:0];
      dvs_q <= divisor_i;
      ovf_q <= ({{(DataW-FracW){1'b0}}, dividend_i[DataW+FracW-1:DataW]} >= divisor_i);
    end else begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.ovf      = ovf_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ hw/rtl/rpn_stack_calculator.sv @@
// A push, an error or an unused code strobes done_o in the cycle after acceptance;
// arithmetic passes S_FETCH, multiply then S_MUL, divide then S_DIV for the 32
// iterations of the bit-serial divider. start is taken again in the cycle that
// shows the strobe. The top of stack sits in a register and the entries below
// it in a one-port-read stack memory. rst_ni clears the depth and all control
// state asynchronously; stack contents are not cleared. Results cannot be stalled.
module rpn_stack_calculator import rpn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  rpn_req_t req_i,
  output logic     busy,
  output logic     done_o,
  output rpn_rsp_t rsp_o
);

  localparam int unsigned MulW = 2 * DataW - FracW;

  rpn_state_e state_q, state_d;

  logic [DataW-1:0]          stack_mem [DEPTH];
  logic [DataW-1:0]          rd_q;
  logic [AddrW-1:0]          rd_addr;
  logic                      mem_we;
  logic [AddrW-1:0]          mem_wa;

  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [CntW-1:0]           cnt_m1, cnt_m2;
  logic [DataW-1:0]          top_q, top_d;
  logic [OpW-1:0]            op_q;
  logic signed [2*DataW-1:0] prod_q, prod_d;
  logic                      neg_q;
  logic                      done_q;
  rpn_rsp_t                  rsp_q, rsp_d;

  logic                      accept;
  logic                      is_oper;
  logic                      enough;
  logic                      go_op;
  logic                      fin;
  logic [StatusW-1:0]        status;
  logic                      sat;

  logic [DataW:0]            sum;
  logic signed [MulW-1:0]    mq;
  logic [MulW-DataW:0]       mq_hi;
  logic [DataW-1:0]          mag_l, mag_r;
  logic [DataW-1:0]          quo;
  logic                      div_start;
  rpn_div_rsp_t              div_rsp;
  logic [CntW+DepthFieldW-1:0] depth_ext;

  // Decode of the incoming transaction.
  assign accept  = start && (state_q == S_IDLE);
  assign cnt_m1  = cnt_q - CntW'(1);
  assign cnt_m2  = cnt_q - CntW'(2);
  assign is_oper = (req_i.operation == OP_ADD) || (req_i.operation == OP_SUB) ||
                   (req_i.operation == OP_MUL) || (req_i.operation == OP_DIV);
  assign enough  = (cnt_q >= CntW'(2));
  assign go_op   = accept && is_oper && enough &&
                   !((req_i.operation == OP_DIV) && (top_q == '0));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (go_op) state_d = S_FETCH;
      end
      S_FETCH: begin
        if (op_q == OP_MUL)      state_d = S_MUL;
        else if (op_q == OP_DIV) state_d = S_DIV;
        else                     state_d = S_IDLE;
      end
      S_MUL: begin
        state_d = S_IDLE;
      end
      S_DIV: begin
        if (div_rsp.done) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Operand magnitudes for the divider; left comes from memory, right is the top.
  assign mag_l = rd_q[DataW-1]  ? (~rd_q + DataW'(1))  : rd_q;
  assign mag_r = top_q[DataW-1] ? (~top_q + DataW'(1)) : top_q;

  // Multiply: drop the fraction bits, rounding toward zero.
  assign mq    = $signed(prod_q[2*DataW-1:FracW]) +
                 $signed({{(MulW-1){1'b0}}, prod_q[2*DataW-1] && (prod_q[FracW-1:0] != '0)});
  assign mq_hi = mq[MulW-1:DataW-1];

  // Add or subtract with one guard bit.
  assign sum = (op_q == OP_ADD) ? ({rd_q[DataW-1], rd_q} + {top_q[DataW-1], top_q})
                                : ({rd_q[DataW-1], rd_q} - {top_q[DataW-1], top_q});

  assign quo = div_rsp.quotient;

  // Datapath and memory control.
  always_comb begin
    cnt_d     = cnt_q;
    top_d     = top_q;
    fin       = 1'b0;
    status    = ST_OK;
    sat       = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = cnt_m1[AddrW-1:0];
    rd_addr   = cnt_m2[AddrW-1:0];
    div_start = 1'b0;
    prod_d    = prod_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          fin = !go_op;
          case (req_i.operation)
            OP_PUSH: begin
              if (cnt_q >= CntW'(DEPTH)) begin
                status = ST_OVERFLOW;
              end else begin
                // The old top moves down into the memory.
                mem_we = (cnt_q != '0);
                top_d  = req_i.operand_value;
                cnt_d  = cnt_q + CntW'(1);
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
              if (!enough)                 status = ST_UNDERFLOW;
              else if (!go_op)             status = ST_DIVZERO;
            end
            default: begin
              status = ST_OK;
            end
          endcase
        end
      end
      S_FETCH: begin
        if (op_q == OP_MUL) begin
          prod_d = $signed(rd_q) * $signed(top_q);
        end else if (op_q == OP_DIV) begin
          div_start = 1'b1;
        end else begin
          fin   = 1'b1;
          sat   = (sum[DataW] != sum[DataW-1]);
          top_d = sat ? (sum[DataW] ? ValMin : ValMax) : sum[DataW-1:0];
          cnt_d = cnt_m1;
        end
      end
      S_MUL: begin
        fin   = 1'b1;
        sat   = (mq_hi != '0) && (mq_hi != '1);
        top_d = sat ? (mq[MulW-1] ? ValMin : ValMax) : mq[DataW-1:0];
        cnt_d = cnt_m1;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          fin   = 1'b1;
          cnt_d = cnt_m1;
          if (div_rsp.ovf) begin
            sat   = 1'b1;
            top_d = neg_q ? ValMin : ValMax;
          end else if (neg_q) begin
            sat   = (quo > ValMin);
            top_d = sat ? ValMin : (~quo + DataW'(1));
          end else begin
            sat   = quo[DataW-1];
            top_d = sat ? ValMax : quo;
          end
        end
      end
      default: begin
        fin = 1'b0;
      end
    endcase
    if (sat) status = ST_SATURATED;
  end

  // Result transaction built from the next stack state.
  assign depth_ext         = {{DepthFieldW{1'b0}}, cnt_d};
  assign rsp_d.status      = status;
  assign rsp_d.top_value   = (cnt_d != '0) ? top_d : '0;
  assign rsp_d.stack_depth = depth_ext[DepthFieldW-1:0];

  rpn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({mag_l, {FracW{1'b0}}}),
    .divisor_i  (mag_r),
    .rsp_o      (div_rsp)
  );

  // Stack memory below the top entry, registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) stack_mem[mem_wa] <= top_q;
    rd_q <= stack_mem[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= fin;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    prod_q <= prod_d;
    if (accept) op_q <= req_i.operation;
    if (div_start) neg_q <= rd_q[DataW-1] ^ top_q[DataW-1];
    if (fin) rsp_q <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

@@ hw/rtl/rpn_checker.sv @@
// Port-level checker of the RPN stack calculator and its bind statement.
// Depends on rpn_pkg and rpn_stack_calculator_defines.svh.
`include "rpn_stack_calculator_defines.svh"

module rpn_checker import rpn_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input rpn_req_t req_i,
  input logic     busy,
  input logic     done_o,
  input rpn_rsp_t rsp_o
);

  // A push transaction reports in the very next cycle.
  `RPN_ASSERT(a_push_latency, (start && !busy && (req_i.operation == OP_PUSH)) |=> done_o, "push result missing")

  // An empty stack shows a zero top.
  `RPN_ASSERT(a_empty_top, (done_o && (rsp_o.stack_depth == '0)) |-> (rsp_o.top_value == '0), "nonzero top on empty stack")

  // Division by zero leaves the zero divisor on top.
  `RPN_ASSERT(a_divzero_top, (done_o && (rsp_o.status == ST_DIVZERO)) |-> (rsp_o.top_value == '0), "divide by zero with nonzero top")

  // Nothing is busy or reported while reset is applied.
  `RPN_ASSERT_RST(a_reset_quiet, !rst_ni |-> (!done_o && !busy), "activity during reset")

endmodule

bind rpn_stack_calculator rpn_checker u_rpn_checker (.*);
